/* rtl/rtcsm_pkg.sv */
// Package: shared types, codes and BCD helpers for the three-wire RTC master.
package rtcsm_pkg;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [7:0] CMD_BASE    = 8'h80;
	localparam int         PhaseW      = 6;
	localparam logic [PhaseW-1:0] DATA_PHASE = 6'd16;
	localparam logic [PhaseW-1:0] LAST_PHASE = 6'd31;
	localparam logic [PhaseW-1:0] END_PHASE  = 6'd32;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] register_select;
		logic [7:0] write_data;
		logic       convert_bcd;
		logic       io_in;
	} req_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       io_out;
		logic       io_drive;
		logic       busy_res;
		logic       request_rejected;
		logic       read_valid;
		logic [7:0] read_raw;
		logic [7:0] read_value;
	} rsp_t;

	// binary to BCD; tens by reciprocal multiply (exact for 0..255)
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  tens;
		logic [7:0]  tens10;
		logic [7:0]  units;
		p      = 16'(v) * 16'd205;
		tens   = p[15:11];
		tens10 = 8'({3'b000, tens} * 8'd10);
		units  = v - tens10;
		return {tens[3:0], 4'b0000} + units;
	endfunction

	function automatic logic [7:0] from_bcd(input logic [7:0] v);
		return 8'({4'b0000, v[7:4]} * 8'd10) + {4'b0000, v[3:0]};
	endfunction

endpackage

/* rtl/rtcsm_req_if.sv */
// Interface: request channel, one tick item per valid/ready handshake.
interface rtcsm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [4:0] register_select;
	logic [7:0] write_data;
	logic       convert_bcd;
	logic       io_in;

	modport source(output valid, mode, register_select, write_data, convert_bcd, io_in,
		input ready);
	modport sink(input valid, mode, register_select, write_data, convert_bcd, io_in,
		output ready);
endinterface

/* rtl/rtcsm_rsp_if.sv */
// Interface: result channel, pin levels and read data per tick.
interface rtcsm_rsp_if;
	logic       valid;
	logic       ready;
	logic       chip_enable;
	logic       serial_clock;
	logic       io_out;
	logic       io_drive;
	logic       busy_res;
	logic       request_rejected;
	logic       read_valid;
	logic [7:0] read_raw;
	logic [7:0] read_value;

	modport source(output valid, chip_enable, serial_clock, io_out, io_drive, busy_res,
		request_rejected, read_valid, read_raw, read_value, input ready);
	modport sink(input valid, chip_enable, serial_clock, io_out, io_drive, busy_res,
		request_rejected, read_valid, read_raw, read_value, output ready);
endinterface

/* rtl/rtc_three_wire_serial_master.sv */
// Top level: three-wire RTC serial master with registered request and result.
// Throughput: one tick per cycle unless the result side stalls (rsp.ready low);
// the transfer state advances once per tick.
// A transfer is 33 ticks: 16 command phases, 16 data phases, one ending tick.
// Reset (arst_n low, asynchronous) clears the transfer state and the valid flags
// of both channel registers; the master comes up idle.
module rtc_three_wire_serial_master (
	input  logic        clk,
	input  logic        arst_n,
	rtcsm_req_if.sink   cmd,
	rtcsm_rsp_if.source rsp
);

	logic             valid_s1;
	rtcsm_pkg::req_t  req_s1;
	logic             out_valid_q;
	rtcsm_pkg::rsp_t  out_q;
	rtcsm_pkg::rsp_t  res;
	logic             advance;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			req_s1.mode            <= cmd.mode;
			req_s1.register_select <= cmd.register_select;
			req_s1.write_data      <= cmd.write_data;
			req_s1.convert_bcd     <= cmd.convert_bcd;
			req_s1.io_in           <= cmd.io_in;
		end
	end

	rtcsm_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.rsp    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.chip_enable      = out_q.chip_enable;
	assign rsp.serial_clock     = out_q.serial_clock;
	assign rsp.io_out           = out_q.io_out;
	assign rsp.io_drive         = out_q.io_drive;
	assign rsp.busy_res         = out_q.busy_res;
	assign rsp.request_rejected = out_q.request_rejected;
	assign rsp.read_valid       = out_q.read_valid;
	assign rsp.read_raw         = out_q.read_raw;
	assign rsp.read_value       = out_q.read_value;

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.read_valid |-> !rsp.busy_res && !rsp.chip_enable)
		else $error("read result while transfer still active");

	a_sclk_ce: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.serial_clock |-> rsp.chip_enable)
		else $error("SCLK high without chip enable");

	a_idle_pin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.io_drive |-> !rsp.io_out)
		else $error("data level driven while pin released");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed tick lost its result");

endmodule

/* rtl/rtcsm_step.sv */
// Transfer state and per-tick sequencing logic of the serial master.
module rtcsm_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  rtcsm_pkg::req_t    req,
	output rtcsm_pkg::rsp_t    rsp
);

	logic [rtcsm_pkg::PhaseW-1:0] phase_q;
	logic [7:0] cmd_shift_q;
	logic [7:0] data_shift_q;
	logic       is_read_q;
	logic       active_q;
	logic       conv_q;

	logic                          start;
	logic                          act_e;
	logic                          isr_e;
	logic                          conv_e;
	logic [7:0]                    cmd_e;
	logic [7:0]                    data_e;
	logic [rtcsm_pkg::PhaseW-1:0]  ph_e;
	logic [7:0]                    data_n;
	logic                          act_n;
	logic [rtcsm_pkg::PhaseW-1:0]  ph_n;
	logic [rtcsm_pkg::PhaseW-1:0]  rel;
	logic [2:0]                    bit_i;

	always_comb begin
		start = (req.mode == rtcsm_pkg::MODE_WRITE) || (req.mode == rtcsm_pkg::MODE_READ);
		act_e  = active_q;
		isr_e  = is_read_q;
		conv_e = conv_q;
		cmd_e  = cmd_shift_q;
		data_e = data_shift_q;
		ph_e   = phase_q;
		if (!active_q && start) begin
			act_e  = 1'b1;
			isr_e  = (req.mode == rtcsm_pkg::MODE_READ);
			conv_e = req.convert_bcd;
			cmd_e  = rtcsm_pkg::CMD_BASE | {2'b00, req.register_select, 1'b0}
				| {7'd0, isr_e};
			data_e = isr_e ? 8'd0 :
				(req.convert_bcd ? rtcsm_pkg::to_bcd(req.write_data) : req.write_data);
			ph_e   = '0;
		end

		rsp        = '0;
		rsp.request_rejected = active_q && start;
		data_n     = data_e;
		act_n      = act_e;
		rel        = ph_e - rtcsm_pkg::DATA_PHASE;
		bit_i      = ph_e < rtcsm_pkg::DATA_PHASE ? ph_e[3:1] : rel[3:1];

		if (act_e) begin
			if (ph_e < rtcsm_pkg::DATA_PHASE) begin
				rsp.chip_enable  = 1'b1;
				rsp.io_drive     = 1'b1;
				rsp.io_out       = cmd_e[bit_i];
				rsp.serial_clock = ph_e[0];
			end else if (ph_e < rtcsm_pkg::END_PHASE) begin
				rsp.chip_enable = 1'b1;
				if (!isr_e) begin
					rsp.io_drive     = 1'b1;
					rsp.io_out       = data_e[bit_i];
					rsp.serial_clock = ph_e[0];
				end else if (ph_e[0]) begin
					data_n[bit_i]    = data_e[bit_i] | req.io_in;
					rsp.serial_clock = (ph_e != rtcsm_pkg::LAST_PHASE);
				end
			end else begin
				if (isr_e) begin
					rsp.read_valid = 1'b1;
					rsp.read_raw   = data_e;
					rsp.read_value = conv_e ? rtcsm_pkg::from_bcd(data_e) : data_e;
				end
				act_n = 1'b0;
			end
		end
		ph_n         = act_n ? ph_e + 6'd1 : '0;
		rsp.busy_res = act_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			cmd_shift_q  <= '0;
			data_shift_q <= '0;
			is_read_q    <= 1'b0;
			active_q     <= 1'b0;
			conv_q       <= 1'b0;
		end else if (en) begin
			phase_q      <= act_e ? ph_n : phase_q;
			cmd_shift_q  <= cmd_e;
			data_shift_q <= data_n;
			is_read_q    <= isr_e;
			active_q     <= act_n;
			conv_q       <= conv_e;
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench: random and directed ticks into the three-wire RTC master, checked per field.
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	class rtc_link_board;
		logic [5:0] phase;
		logic [7:0] cmd_byte;
		logic [7:0] data_byte;
		logic       reading;
		logic       active;
		logic       conv;
		rtcsm_pkg::rsp_t expected_pins[$];
		int         errors;

		function new();
			phase = '0;
			cmd_byte = '0;
			data_byte = '0;
			reading = 1'b0;
			active = 1'b0;
			conv = 1'b0;
			errors = 0;
		endfunction

		function logic [7:0] bcd_pack(logic [7:0] v);
			int unsigned n;
			n = v;
			return 8'(((n / 10) * 16) + (n % 10));
		endfunction

		function logic [7:0] bcd_unpack(logic [7:0] v);
			int unsigned n;
			n = v;
			return 8'(((n / 16) * 10) + (n % 16));
		endfunction

		function rtcsm_pkg::rsp_t next_pins(rtcsm_pkg::req_t t);
			rtcsm_pkg::rsp_t r;
			logic       start;
			logic [2:0] bit_idx;
			r = '0;
			start = (t.mode == rtcsm_pkg::MODE_WRITE) || (t.mode == rtcsm_pkg::MODE_READ);
			if (active) begin
				if (start)
					r.request_rejected = 1'b1;
			end else if (start) begin
				reading = (t.mode == rtcsm_pkg::MODE_READ);
				conv = t.convert_bcd;
				cmd_byte = rtcsm_pkg::CMD_BASE | {2'b00, t.register_select, reading};
				data_byte = reading ? 8'h00 : (conv ? bcd_pack(t.write_data) : t.write_data);
				phase = '0;
				active = 1'b1;
			end
			if (active) begin
				bit_idx = phase[3:1];
				if (phase < rtcsm_pkg::DATA_PHASE) begin
					r.chip_enable = 1'b1;
					r.io_drive = 1'b1;
					r.io_out = cmd_byte[bit_idx];
					r.serial_clock = phase[0];
				end else if (phase < rtcsm_pkg::END_PHASE) begin
					r.chip_enable = 1'b1;
					if (!reading) begin
						r.io_drive = 1'b1;
						r.io_out = data_byte[bit_idx];
						r.serial_clock = phase[0];
					end else if (phase[0]) begin
						data_byte[bit_idx] = data_byte[bit_idx] | t.io_in;
						r.serial_clock = (phase != rtcsm_pkg::LAST_PHASE);
					end
				end else begin
					if (reading) begin
						r.read_valid = 1'b1;
						r.read_raw = data_byte;
						r.read_value = conv ? bcd_unpack(data_byte) : data_byte;
					end
					active = 1'b0;
				end
				phase = active ? phase + 6'd1 : 6'd0;
			end
			r.busy_res = active;
			return r;
		endfunction

		function void note_tick(rtcsm_pkg::req_t t);
			expected_pins.push_back(next_pins(t));
		endfunction

		function void flag_field(string name, int unsigned exp_v, int unsigned got_v);
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
			errors++;
		endfunction

		function void check_pins(rtcsm_pkg::rsp_t g);
			rtcsm_pkg::rsp_t e;
			if (expected_pins.size() == 0) begin
				$display("%0t: result with nothing expected, got %0h", $time, g);
				errors++;
				return;
			end
			e = expected_pins.pop_front();
			if (g.chip_enable !== e.chip_enable)
				flag_field("chip_enable", e.chip_enable, g.chip_enable);
			if (g.serial_clock !== e.serial_clock)
				flag_field("serial_clock", e.serial_clock, g.serial_clock);
			if (g.io_out !== e.io_out)
				flag_field("io_out", e.io_out, g.io_out);
			if (g.io_drive !== e.io_drive)
				flag_field("io_drive", e.io_drive, g.io_drive);
			if (g.busy_res !== e.busy_res)
				flag_field("busy_res", e.busy_res, g.busy_res);
			if (g.request_rejected !== e.request_rejected)
				flag_field("request_rejected", e.request_rejected, g.request_rejected);
			if (g.read_valid !== e.read_valid)
				flag_field("read_valid", e.read_valid, g.read_valid);
			if (g.read_raw !== e.read_raw)
				flag_field("read_raw", e.read_raw, g.read_raw);
			if (g.read_value !== e.read_value)
				flag_field("read_value", e.read_value, g.read_value);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	int   ticks_sent;

	rtcsm_req_if cmd_if();
	rtcsm_rsp_if rsp_if();

	rtc_link_board board = new();

	rtc_three_wire_serial_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rsp(rsp_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic rtcsm_pkg::req_t make_tick(logic [1:0] mode);
		rtcsm_pkg::req_t t;
		t.mode = mode;
		t.register_select = 5'($urandom_range(0, 31));
		t.write_data = 8'($urandom_range(0, 255));
		t.convert_bcd = 1'($urandom_range(0, 1));
		t.io_in = 1'($urandom_range(0, 1));
		return t;
	endfunction

	task automatic send_tick(input rtcsm_pkg::req_t t);
		if (!calm && $urandom_range(0, 9) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.mode <= t.mode;
		cmd_if.register_select <= t.register_select;
		cmd_if.write_data <= t.write_data;
		cmd_if.convert_bcd <= t.convert_bcd;
		cmd_if.io_in <= t.io_in;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		board.note_tick(t);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic run_transfer();
		rtcsm_pkg::req_t t;
		int   pin_style;
		while (board.active)
			send_tick(make_tick(rtcsm_pkg::MODE_TICK));
		t = make_tick($urandom_range(0, 1) ? rtcsm_pkg::MODE_READ
			: rtcsm_pkg::MODE_WRITE);
		if (t.convert_bcd && $urandom_range(0, 3) != 0)
			t.write_data = 8'($urandom_range(0, 99));
		pin_style = $urandom_range(0, 3);
		send_tick(t);
		for (int k = 1; k <= 32; k++) begin
			t = make_tick(rtcsm_pkg::MODE_TICK);
			if (pin_style < 2)
				t.io_in = 1'(pin_style);
			if ((k == 32 && $urandom_range(0, 3) == 0) || $urandom_range(0, 19) == 0)
				t.mode = 2'($urandom_range(1, 3));
			send_tick(t);
		end
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 20))
			send_tick(make_tick(2'($urandom_range(0, 3))));
	endtask

	// stimulus
	initial begin
		rtcsm_pkg::req_t t;
		arst_n = 1'b0;
		calm = 1'b0;
		ticks_sent = 0;
		cmd_if.valid = 1'b0;
		cmd_if.mode = rtcsm_pkg::MODE_TICK;
		cmd_if.register_select = '0;
		cmd_if.write_data = '0;
		cmd_if.convert_bcd = 1'b0;
		cmd_if.io_in = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		t = '{mode: rtcsm_pkg::MODE_TICK, register_select: 5'h1f, write_data: 8'hff,
			convert_bcd: 1'b1, io_in: 1'b1};
		send_tick(t);
		t.mode = MODE_SPARE;
		send_tick(t);
		// write with out-of-range BCD data, then starts while busy
		t.mode = rtcsm_pkg::MODE_WRITE;
		send_tick(t);
		t = '{mode: rtcsm_pkg::MODE_READ, register_select: 5'h00, write_data: 8'h00,
			convert_bcd: 1'b0, io_in: 1'b0};
		send_tick(t);
		t.mode = rtcsm_pkg::MODE_WRITE;
		send_tick(t);
		t.mode = MODE_SPARE;
		send_tick(t);
		for (int k = 0; k < 19; k++) begin
			t.mode = rtcsm_pkg::MODE_TICK;
			t.io_in = 1'(k);
			send_tick(t);
		end
		while (board.active)
			send_tick(make_tick(rtcsm_pkg::MODE_TICK));
		// read of all ones with conversion, start on the ending tick
		t = '{mode: rtcsm_pkg::MODE_READ, register_select: 5'h1f, write_data: 8'h00,
			convert_bcd: 1'b1, io_in: 1'b1};
		send_tick(t);
		for (int k = 1; k <= 32; k++) begin
			t.mode = (k == 32) ? rtcsm_pkg::MODE_READ : rtcsm_pkg::MODE_TICK;
			send_tick(t);
		end

		while (ticks_sent < 1450) begin
			if (ticks_sent >= 1300)
				calm = 1'b1;
			case ($urandom_range(0, 9))
				0: run_noise();
				1: begin
					repeat ($urandom_range(1, 5))
						send_tick(make_tick($urandom_range(0, 1) ? rtcsm_pkg::MODE_TICK
							: MODE_SPARE));
				end
				default: run_transfer();
			endcase
		end
		calm = 1'b1;
		cmd_if.valid <= 1'b0;

		while (board.expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (board.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// result side stalls
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 15) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_pins('{chip_enable: rsp_if.chip_enable,
				serial_clock: rsp_if.serial_clock, io_out: rsp_if.io_out,
				io_drive: rsp_if.io_drive, busy_res: rsp_if.busy_res,
				request_rejected: rsp_if.request_rejected, read_valid: rsp_if.read_valid,
				read_raw: rsp_if.read_raw, read_value: rsp_if.read_value});
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
